// ----- src/sti_pkg.sv -----
package sti_pkg;

    localparam int unsigned POS_W   = 3;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned SCORE_W = 32;
    localparam int unsigned NAME_W  = 64;
    localparam int unsigned INDEX_W = 3;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic {
        MODE_LOWEST  = 1'b0,
        MODE_HIGHEST = 1'b1
    } t_order_mode;

    // handed from one cell to the next
    typedef struct packed {
        logic found;  // insert point lies at or before the sending cell
        logic valid;  // sending cell holds an entry
    } t_link;

endpackage

// ----- src/sti_cell.sv -----
module sti_cell #(
    parameter int unsigned CELL_NAME_W = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  sti_pkg::t_order_mode          i_mode,
    input  logic [sti_pkg::SCORE_W-1:0]   i_new_score,
    input  logic [CELL_NAME_W-1:0]        i_new_name,
    input  sti_pkg::t_link                i_link,
    input  logic [sti_pkg::SCORE_W-1:0]   i_left_score,
    input  logic [CELL_NAME_W-1:0]        i_left_name,
    output sti_pkg::t_link                o_link,
    output logic                          o_is_pos,
    output logic [sti_pkg::SCORE_W-1:0]   o_score,
    output logic [CELL_NAME_W-1:0]        o_name
);
    import sti_pkg::*;

    logic                   r_valid;
    logic [SCORE_W-1:0]     r_score;
    logic [CELL_NAME_W-1:0] r_name;
    logic                   ranks_after;

    // stored entry ranks strictly after the new score
    assign ranks_after = (i_mode == MODE_HIGHEST) ? (r_score < i_new_score)
                                                  : (r_score > i_new_score);

    assign o_is_pos     = !i_link.found && (!r_valid || ranks_after);
    assign o_link.found = i_link.found || o_is_pos;
    assign o_link.valid = r_valid;
    assign o_score      = r_score;
    assign o_name       = r_name;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            if (i_link.found) begin
                r_valid <= i_link.valid;
            end else if (o_is_pos) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (i_link.found) begin
                r_score <= i_left_score;
                r_name  <= i_left_name;
            end else if (o_is_pos) begin
                r_score <= i_new_score;
                r_name  <= i_new_name;
            end
        end
    end

endmodule

// ----- src/sorted_topk_insert_table_unit.sv -----
// the result strobe o_done rises the cycle after start is taken
// throughput: one transaction per cycle, busy stays low and the receiver cannot stall
// an insert is placed by the row of cells comparing and shifting together
// reset (synchronous, active low) empties the table and selects keep-lowest order
// entry storage is not cleared, only the per-cell valid bits and the count
module sorted_topk_insert_table_unit #(
    parameter int unsigned MAX_ENTRIES = 8,
    parameter int unsigned NAME_BYTES  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [sti_pkg::SCORE_W-1:0]   i_entry_score,
    input  logic [sti_pkg::NAME_W-1:0]    i_entry_name,
    input  logic [sti_pkg::INDEX_W-1:0]   i_read_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_order_mode,
    output logic                          o_done,
    output logic                          o_inserted,
    output logic [sti_pkg::POS_W-1:0]     o_insert_position,
    output logic [sti_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_read_valid,
    output logic [sti_pkg::SCORE_W-1:0]   o_read_score,
    output logic [sti_pkg::NAME_W-1:0]    o_read_name
);
    import sti_pkg::*;

    localparam int unsigned CELL_NAME_W = NAME_BYTES * 8;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned PW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_link                  link   [MAX_ENTRIES+1];
    logic [SCORE_W-1:0]     score  [MAX_ENTRIES+1];
    logic [CELL_NAME_W-1:0] name_q [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] is_pos;
    logic [MAX_ENTRIES-1:0] valid_vec;

    t_order_mode   r_mode;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                 r_done;
    logic                 r_inserted;
    logic [POS_W-1:0]     r_insert_position;
    logic [COUNT_W-1:0]   r_entry_count;
    logic                 r_read_valid;
    logic [SCORE_W-1:0]   r_read_score;
    logic [NAME_W-1:0]    r_read_name;

    logic                 take;
    logic                 do_insert;
    logic                 placed;
    logic [PW-1:0]        pos;
    logic [PW+POS_W-1:0]  pos_wide;
    logic [CW+COUNT_W-1:0] count_wide;
    logic [CW+INDEX_W-1:0] idx_cmp;
    logic [CW+INDEX_W-1:0] cnt_cmp;
    logic                 rd_valid;
    logic [SCORE_W-1:0]   rd_score;
    logic [CELL_NAME_W-1:0] rd_name;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign take        = start && !busy;
    assign do_insert   = take && (t_opcode'(i_opcode) == OP_INSERT);

    assign link[0]   = '{found: 1'b0, valid: 1'b0};
    assign score[0]  = '0;
    assign name_q[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        sti_cell #(
            .CELL_NAME_W(CELL_NAME_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (do_insert),
            .i_mode      (r_mode),
            .i_new_score (i_entry_score),
            .i_new_name  (i_entry_name[CELL_NAME_W-1:0]),
            .i_link      (link[g]),
            .i_left_score(score[g]),
            .i_left_name (name_q[g]),
            .o_link      (link[g+1]),
            .o_is_pos    (is_pos[g]),
            .o_score     (score[g+1]),
            .o_name      (name_q[g+1])
        );
        assign valid_vec[g] = link[g+1].valid;
    end

    assign placed = link[MAX_ENTRIES].found;

    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (is_pos[i]) begin
                pos = pos | PW'(i);
            end
        end
    end

    assign pos_wide = {{POS_W{1'b0}}, pos};

    always_comb begin
        n_count = r_count;
        if (do_insert && placed && (r_count < CW'(MAX_ENTRIES))) begin
            n_count = r_count + CW'(1);
        end
    end

    assign count_wide = {{COUNT_W{1'b0}}, n_count};
    assign idx_cmp    = {{CW{1'b0}}, i_read_index};
    assign cnt_cmp    = {{INDEX_W{1'b0}}, r_count};
    assign rd_valid   = idx_cmp < cnt_cmp;

    always_comb begin
        rd_score = '0;
        rd_name  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((i < (1 << INDEX_W)) && (int'(i_read_index) == i)) begin
                rd_score = score[i+1];
                rd_name  = name_q[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_LOWEST;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_order_mode'(i_cfg_order_mode);
            end
            r_count <= n_count;
            r_done  <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry_count <= count_wide[COUNT_W-1:0];
            if (t_opcode'(i_opcode) == OP_INSERT) begin
                r_inserted        <= placed;
                r_insert_position <= placed ? pos_wide[POS_W-1:0] : '0;
                r_read_valid      <= 1'b0;
                r_read_score      <= '0;
                r_read_name       <= '0;
            end else begin
                r_inserted        <= 1'b0;
                r_insert_position <= '0;
                r_read_valid      <= rd_valid;
                r_read_score      <= rd_valid ? rd_score : '0;
                r_read_name       <= rd_valid ? NAME_W'(rd_name) : '0;
            end
        end
    end

    assign o_done            = r_done;
    assign o_inserted        = r_inserted;
    assign o_insert_position = r_insert_position;
    assign o_entry_count     = r_entry_count;
    assign o_read_valid      = r_read_valid;
    assign o_read_score      = r_read_score;
    assign o_read_name       = r_read_name;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_done)
        else $error("transaction produced no result");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> !o_done)
        else $error("result without transaction");

    a_insert_or_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_inserted && o_read_valid))
        else $error("result flags both insert and read");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sti_pkg::*;

    localparam int MAX_ENTRIES   = 8;
    localparam int NAME_BYTES    = 8;
    localparam int SETTLE_CYCLES = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 200;
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (NAME_W - 8 * NAME_BYTES);

    typedef enum logic [1:0] {
        REQ_OP,
        REQ_MODE,
        REQ_HOLD
    } req_kind_e;

    typedef struct packed {
        req_kind_e            kind;
        t_opcode              opcode;
        logic [SCORE_W-1:0]   score;
        logic [NAME_W-1:0]    name;
        logic [INDEX_W-1:0]   index;
        t_order_mode          mode;
    } table_req_t;

    typedef struct packed {
        logic                 inserted;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   count;
        logic                 read_valid;
        logic [SCORE_W-1:0]   score;
        logic [NAME_W-1:0]    name;
    } table_result_t;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 start            = 1'b0;
    logic                 busy;
    logic                 i_opcode         = 1'b0;
    logic [SCORE_W-1:0]   i_entry_score    = '0;
    logic [NAME_W-1:0]    i_entry_name     = '0;
    logic [INDEX_W-1:0]   i_read_index     = '0;
    logic                 i_cfg_valid      = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_order_mode = 1'b0;
    logic                 o_done;
    logic                 o_inserted;
    logic [POS_W-1:0]     o_insert_position;
    logic [COUNT_W-1:0]   o_entry_count;
    logic                 o_read_valid;
    logic [SCORE_W-1:0]   o_read_score;
    logic [NAME_W-1:0]    o_read_name;

    sorted_topk_insert_table_unit #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_entry_score    (i_entry_score),
        .i_entry_name     (i_entry_name),
        .i_read_index     (i_read_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_order_mode (i_cfg_order_mode),
        .o_done           (o_done),
        .o_inserted       (o_inserted),
        .o_insert_position(o_insert_position),
        .o_entry_count    (o_entry_count),
        .o_read_valid     (o_read_valid),
        .o_read_score     (o_read_score),
        .o_read_name      (o_read_name)
    );

    // shadow copy of the ranked table
    logic [SCORE_W-1:0]   rank_score [MAX_ENTRIES];
    logic [NAME_W-1:0]    rank_name  [MAX_ENTRIES];
    int                   rank_count = 0;
    t_order_mode          rank_mode  = MODE_LOWEST;

    table_req_t           pending_ops[$];
    table_result_t        predicted_results[$];

    bit                   xfer_taken   = 1'b0;
    bit                   cfg_taken    = 1'b0;
    int                   mismatches   = 0;
    int                   cycle_count  = 0;
    int                   gap_left     = 0;
    int                   run_left     = 0;
    bit                   idle_run     = 1'b0;
    int                   quiet_cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit ranks_later(input logic [SCORE_W-1:0] stored,
                                       input logic [SCORE_W-1:0] fresh);
        if (rank_mode == MODE_HIGHEST) begin
            return stored < fresh;
        end
        return stored > fresh;
    endfunction

    task automatic rank_table_apply(input table_req_t req, output table_result_t res);
        int pos;
        pos = 0;
        res = '0;
        if (req.opcode == OP_INSERT) begin
            while (pos < rank_count && !ranks_later(rank_score[pos], req.score)) begin
                pos++;
            end
            if (pos < MAX_ENTRIES) begin
                if (rank_count < MAX_ENTRIES) begin
                    rank_count++;
                end
                for (int i = rank_count - 1; i > pos; i--) begin
                    rank_score[i] = rank_score[i-1];
                    rank_name[i]  = rank_name[i-1];
                end
                rank_score[pos] = req.score;
                rank_name[pos]  = req.name & NAME_MASK;
                res.inserted    = 1'b1;
                res.position    = POS_W'(pos);
            end
        end else if (req.index < rank_count) begin
            res.read_valid = 1'b1;
            res.score      = rank_score[req.index];
            res.name       = rank_name[req.index];
        end
        res.count = COUNT_W'(rank_count);
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic push_insert(input logic [SCORE_W-1:0] score, input logic [NAME_W-1:0] name);
        table_req_t req;
        req        = '0;
        req.kind   = REQ_OP;
        req.opcode = OP_INSERT;
        req.score  = score;
        req.name   = name;
        req.index  = INDEX_W'($urandom_range(0, 7));
        pending_ops.push_back(req);
    endtask

    task automatic push_read(input logic [INDEX_W-1:0] index);
        table_req_t req;
        req        = '0;
        req.kind   = REQ_OP;
        req.opcode = OP_READ;
        req.score  = $urandom;
        req.name   = {$urandom, $urandom};
        req.index  = index;
        pending_ops.push_back(req);
    endtask

    task automatic push_mode(input t_order_mode mode);
        table_req_t req;
        req      = '0;
        req.kind = REQ_MODE;
        req.mode = mode;
        pending_ops.push_back(req);
    endtask

    task automatic push_hold();
        table_req_t req;
        req      = '0;
        req.kind = REQ_HOLD;
        pending_ops.push_back(req);
    endtask

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 15);
            4, 5, 6:    return $urandom;
            default:    return 32'hFFFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // driver: one transaction or register write at a time
    always @(negedge i_clk) begin : driver
        table_req_t req;
        logic       next_start;
        logic       next_cfg;
        next_start = start;
        next_cfg   = i_cfg_valid;
        if (i_rst_n && !(start && !xfer_taken) && !(i_cfg_valid && !cfg_taken)) begin
            next_start   = 1'b0;
            next_cfg     = 1'b0;
            quiet_cycles = (predicted_results.size() == 0) ? quiet_cycles + 1 : 0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_ops.size() != 0) begin
                if (pending_ops[0].kind == REQ_OP) begin
                    req           = pending_ops.pop_front();
                    i_opcode      <= req.opcode;
                    i_entry_score <= req.score;
                    i_entry_name  <= req.name;
                    i_read_index  <= req.index;
                    next_start    = 1'b1;
                    if (run_left == 0) begin
                        run_left = $urandom_range(8, 60);
                        idle_run = 1'($urandom_range(0, 1));
                    end
                    run_left--;
                    gap_left = idle_run ? $urandom_range(0, 19) : 0;
                end else if (quiet_cycles > SETTLE_CYCLES) begin
                    req          = pending_ops.pop_front();
                    quiet_cycles = 0;
                    if (req.kind == REQ_MODE) begin
                        i_cfg_order_mode <= req.mode;
                        next_cfg         = 1'b1;
                    end
                end
            end
        end
        start       <= next_start;
        i_cfg_valid <= next_cfg;
    end

    // monitor: check results, then record what this edge accepted
    always @(posedge i_clk) begin : monitor
        table_req_t    req;
        table_result_t want;
        if (i_rst_n) begin
            if (o_done !== 1'b0) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with no transaction outstanding, expected none actual %b",
                             $time, o_done);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("inserted", 64'(want.inserted), 64'(o_inserted));
                    check_field("insert_position", 64'(want.position),
                                64'(o_insert_position));
                    check_field("entry_count", 64'(want.count), 64'(o_entry_count));
                    check_field("read_valid", 64'(want.read_valid), 64'(o_read_valid));
                    check_field("read_score", 64'(want.score), 64'(o_read_score));
                    check_field("read_name", want.name, o_read_name);
                end
            end
            xfer_taken = start && !busy;
            if (xfer_taken) begin
                req        = '0;
                req.kind   = REQ_OP;
                req.opcode = t_opcode'(i_opcode);
                req.score  = i_entry_score;
                req.name   = i_entry_name;
                req.index  = i_read_index;
                rank_table_apply(req, want);
                predicted_results.push_back(want);
            end
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (cfg_taken) begin
                rank_mode = t_order_mode'(i_cfg_order_mode);
            end
        end else begin
            xfer_taken = 1'b0;
            cfg_taken  = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // empty table, ties, extremes, full table, rejection and drop-out
        push_read(3'd0);
        push_insert(32'd100, 64'h0123_4567_89AB_CDEF);
        push_insert(32'd100, 64'hFEDC_BA98_7654_3210);
        push_insert(32'd0, '1);
        push_insert(32'hFFFF_FFFF, '0);
        push_read(3'd5);
        push_insert(32'd50, 64'h8000_0000_0000_0001);
        push_insert(32'd200, 64'h00FF_00FF_00FF_00FF);
        push_insert(32'd7, 64'h7F00_0000_0000_0080);
        push_insert(32'd300, 64'h5555_AAAA_5555_AAAA);
        push_insert(32'hFFFF_FFFF, 64'h1111_2222_3333_4444);
        push_insert(32'd1, 64'hAAAA_5555_AAAA_5555);
        push_read(3'd0);
        push_read(3'd7);
        push_read(3'd4);
        // order flips while the table is full and unsorted for the new mode
        push_mode(MODE_HIGHEST);
        push_insert(32'd150, 64'hC0DE_C0DE_C0DE_C0DE);
        push_insert(32'd0, 64'h0000_0000_0000_00FF);
        push_read(3'd0);
        push_read(3'd3);
        push_hold();
        push_mode(MODE_LOWEST);
        push_insert(32'd2, 64'hFF00_0000_0000_0000);
        push_read(3'd7);

        for (int p = 0; p < PHASES; p++) begin
            push_mode((p % 2 == 0) ? MODE_HIGHEST : MODE_LOWEST);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    push_hold();
                end
                if ($urandom_range(0, 99) < 55) begin
                    push_insert(pick_score(), pick_name());
                end else begin
                    push_read(INDEX_W'($urandom_range(0, 7)));
                end
            end
        end

        @(posedge i_rst_n);
        do begin
            @(posedge i_clk);
            #2;
        end while (pending_ops.size() != 0 || start || i_cfg_valid
                   || predicted_results.size() != 0);
        repeat (4) @(posedge i_clk);
        #2;
        if (predicted_results.size() != 0) begin
            $display("%0t: %0d transactions never completed, expected 0 actual %0d",
                     $time, predicted_results.size(), predicted_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
